// ===== rtl/lodd_pkg.sv =====
`timescale 1ns / 1ps

package lodd_pkg;

  // Table sizes.
  localparam int LOCK_SLOTS   = 8;
  localparam int THREAD_SLOTS = 8;
  localparam int EDGE_SLOTS   = 64;

  // Fixed field widths.
  localparam int ID_W   = 8;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;
  localparam int EU_W   = 7;
  localparam int PAIR_W = 2 * ID_W;

  // Derived index and count widths.
  localparam int LIDX_W     = $clog2(LOCK_SLOTS);
  localparam int LCNT_W     = $clog2(LOCK_SLOTS + 1);
  localparam int TIDX_W     = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int TCNT_W     = $clog2(THREAD_SLOTS + 1);
  localparam int EIDX_W     = $clog2(EDGE_SLOTS);
  localparam int ECNT_W     = $clog2(EDGE_SLOTS + 1);
  localparam int HELD_DEPTH = THREAD_SLOTS * LOCK_SLOTS;
  localparam int HADDR_W    = $clog2(HELD_DEPTH);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_DETECT  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_LOCK_FULL   = 3'd1;
  localparam logic [ST_W-1:0] ST_THREAD_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_THREAD   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_HELD    = 3'd4;
  localparam logic [ST_W-1:0] ST_HELD_FULL   = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            clear_tables;
    logic            lock_reg;
    logic            thr_new;
    logic            thr_sel;
    logic            i_clr;
    logic            i_inc;
    logic            e_clr;
    logic            e_inc;
    logic            held_rd;
    logic            held_rd_next;
    logic            held_wr_shift;
    logic            held_push;
    logic            cnt_dec;
    logic            pair_load;
    logic            edge_rd;
    logic            edge_add;
    logic            adj_clr;
    logic            adj_set;
    logic            peel_init;
    logic            peel_step;
    logic            set_status;
    logic            set_cycle;
    logic [ST_W-1:0] st;
  } lodd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            lock_known;
    logic            lock_full;
    logic            thr_found;
    logic            thr_full;
    logic            i_ge_n;
    logic            i1_ge_n;
    logic            e_ge_total;
    logic            edge_full;
    logic            held_full;
    logic            held_match;
    logic            edge_match;
    logic            peel_done;
  } lodd_sts_t;

endpackage

// ===== rtl/lodd_if.sv =====
`timescale 1ns / 1ps

interface lodd_in_if import lodd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [ID_W-1:0] tid;
  logic [ID_W-1:0] lock_id;

  modport source (output valid, op, tid, lock_id, input ready);
  modport sink   (input valid, op, tid, lock_id, output ready);
endinterface

interface lodd_out_if import lodd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic            cycle_found;
  logic [EU_W-1:0] edges_used;

  modport source (output valid, status, cycle_found, edges_used, input ready);
  modport sink   (input valid, status, cycle_found, edges_used, output ready);
endinterface

// ===== rtl/lodd_ram.sv =====
`timescale 1ns / 1ps

module lodd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/lodd_datapath.sv =====
`timescale 1ns / 1ps

module lodd_datapath import lodd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [OP_W-1:0] op_i,
  input  logic [ID_W-1:0] tid_i,
  input  logic [ID_W-1:0] lock_id_i,
  input  lodd_cmd_t       cmd_i,
  output lodd_sts_t       sts_o,
  output logic [ST_W-1:0] status_o,
  output logic            cycle_found_o,
  output logic [EU_W-1:0] edges_used_o
);

  logic [OP_W-1:0]       op_q;
  logic [ID_W-1:0]       tid_q;
  logic [ID_W-1:0]       lid_q;

  logic [ID_W-1:0]       lock_ids_q [LOCK_SLOTS];
  logic [LCNT_W-1:0]     locks_used_q;
  logic [ID_W-1:0]       thread_ids_q [THREAD_SLOTS];
  logic [TCNT_W-1:0]     threads_used_q;
  logic [LCNT_W-1:0]     held_cnt_q [THREAD_SLOTS];

  logic [TIDX_W-1:0]     t_q;
  logic [LCNT_W-1:0]     n_q;
  logic [LCNT_W-1:0]     i_q;
  logic [ECNT_W-1:0]     e_q;
  logic [ECNT_W-1:0]     edge_total_q;
  logic [PAIR_W-1:0]     pair_q;

  logic [LOCK_SLOTS-1:0] adj_q [LOCK_SLOTS];
  logic [LOCK_SLOTS-1:0] done_q;
  logic [LCNT_W-1:0]     k_q;

  logic [ST_W-1:0]       status_q;
  logic                  cyc_q;

  logic                  lock_known;
  logic                  thr_found;
  logic [TIDX_W-1:0]     thr_idx;
  logic [LCNT_W-1:0]     held_idx;
  logic [HADDR_W-1:0]    held_base;
  logic [HADDR_W-1:0]    held_raddr;
  logic [HADDR_W-1:0]    held_waddr;
  logic [ID_W-1:0]       held_wdata;
  logic                  held_we;
  logic [ID_W-1:0]       held_rdata;
  logic [PAIR_W-1:0]     edge_rdata;
  logic [LOCK_SLOTS-1:0] from_hit;
  logic [LOCK_SLOTS-1:0] to_hit;
  logic [LOCK_SLOTS-1:0] peel_zero;
  logic [LCNT_W:0]       i_plus1;
  logic [ECNT_W+EU_W-1:0] total_ext;

  // Parallel lookups in the lock and thread tables.
  always_comb begin
    lock_known = 1'b0;
    for (int k = 0; k < LOCK_SLOTS; k++) begin
      if ((LCNT_W'(k) < locks_used_q) && (lock_ids_q[k] == lid_q)) begin
        lock_known = 1'b1;
      end
    end
  end

  always_comb begin
    thr_found = 1'b0;
    thr_idx   = '0;
    for (int k = THREAD_SLOTS - 1; k >= 0; k--) begin
      if ((TCNT_W'(k) < threads_used_q) && (thread_ids_q[k] == tid_q)) begin
        thr_found = 1'b1;
        thr_idx   = TIDX_W'(k);
      end
    end
  end

  // Map the endpoints of the edge just read onto lock slots.
  always_comb begin
    for (int k = 0; k < LOCK_SLOTS; k++) begin
      from_hit[k] = (LCNT_W'(k) < locks_used_q) &&
                    (lock_ids_q[k] == edge_rdata[PAIR_W-1:ID_W]);
      to_hit[k]   = (LCNT_W'(k) < locks_used_q) &&
                    (lock_ids_q[k] == edge_rdata[ID_W-1:0]);
    end
  end

  // A node peels off when no remaining node has an edge into it.
  always_comb begin
    for (int j = 0; j < LOCK_SLOTS; j++) begin
      peel_zero[j] = 1'b1;
      for (int k = 0; k < LOCK_SLOTS; k++) begin
        if (adj_q[k][j] && !done_q[k]) begin
          peel_zero[j] = 1'b0;
        end
      end
    end
  end

  assign i_plus1    = {1'b0, i_q} + {{LCNT_W{1'b0}}, 1'b1};
  assign held_base  = HADDR_W'(t_q) * HADDR_W'(LOCK_SLOTS);
  assign held_idx   = cmd_i.held_rd_next ? i_plus1[LCNT_W-1:0] : i_q;
  assign held_raddr = held_base + HADDR_W'(held_idx);
  assign held_waddr = held_base + HADDR_W'(cmd_i.held_push ? n_q : i_q);
  assign held_wdata = cmd_i.held_push ? lid_q : held_rdata;
  assign held_we    = cmd_i.held_push | cmd_i.held_wr_shift;

  lodd_ram #(
    .WIDTH (ID_W),
    .DEPTH (HELD_DEPTH)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .waddr_i (held_waddr),
    .wdata_i (held_wdata),
    .raddr_i (held_raddr),
    .rdata_o (held_rdata)
  );

  lodd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (EDGE_SLOTS)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.edge_add),
    .waddr_i (edge_total_q[EIDX_W-1:0]),
    .wdata_i (pair_q),
    .raddr_i (e_q[EIDX_W-1:0]),
    .rdata_o (edge_rdata)
  );

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locks_used_q   <= '0;
      threads_used_q <= '0;
      edge_total_q   <= '0;
      i_q            <= '0;
      e_q            <= '0;
      k_q            <= '0;
    end else begin
      if (cmd_i.clear_tables) begin
        locks_used_q   <= '0;
        threads_used_q <= '0;
        edge_total_q   <= '0;
      end
      if (cmd_i.lock_reg) begin
        locks_used_q <= locks_used_q + LCNT_W'(1);
      end
      if (cmd_i.thr_new) begin
        threads_used_q <= threads_used_q + TCNT_W'(1);
      end
      if (cmd_i.edge_add) begin
        edge_total_q <= edge_total_q + ECNT_W'(1);
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_plus1[LCNT_W-1:0];
      end
      if (cmd_i.e_clr) begin
        e_q <= '0;
      end else if (cmd_i.e_inc) begin
        e_q <= e_q + ECNT_W'(1);
      end
      if (cmd_i.peel_init) begin
        k_q <= '0;
      end else if (cmd_i.peel_step) begin
        k_q <= k_q + LCNT_W'(1);
      end
    end
  end

  // Table contents and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      tid_q <= tid_i;
      lid_q <= lock_id_i;
    end
    if (cmd_i.lock_reg) begin
      lock_ids_q[locks_used_q[LIDX_W-1:0]] <= lid_q;
    end
    if (cmd_i.thr_new) begin
      thread_ids_q[threads_used_q[TIDX_W-1:0]] <= tid_q;
      held_cnt_q[threads_used_q[TIDX_W-1:0]]   <= '0;
      t_q <= threads_used_q[TIDX_W-1:0];
      n_q <= '0;
    end else if (cmd_i.thr_sel) begin
      t_q <= thr_idx;
      n_q <= held_cnt_q[thr_idx];
    end
    if (cmd_i.held_push) begin
      held_cnt_q[t_q] <= n_q + LCNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      held_cnt_q[t_q] <= n_q - LCNT_W'(1);
    end
    if (cmd_i.pair_load) begin
      pair_q <= {held_rdata, lid_q};
    end
    for (int f = 0; f < LOCK_SLOTS; f++) begin
      if (cmd_i.adj_clr) begin
        adj_q[f] <= '0;
      end else if (cmd_i.adj_set && from_hit[f]) begin
        adj_q[f] <= adj_q[f] | to_hit;
      end
    end
    if (cmd_i.peel_init) begin
      for (int k = 0; k < LOCK_SLOTS; k++) begin
        done_q[k] <= !(LCNT_W'(k) < locks_used_q);
      end
    end else if (cmd_i.peel_step) begin
      done_q <= done_q | peel_zero;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.st;
      cyc_q    <= 1'b0;
    end else if (cmd_i.set_cycle) begin
      status_q <= ST_OK;
      cyc_q    <= ~&done_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.lock_known = lock_known;
    sts_o.lock_full  = locks_used_q >= LCNT_W'(LOCK_SLOTS);
    sts_o.thr_found  = thr_found;
    sts_o.thr_full   = threads_used_q >= TCNT_W'(THREAD_SLOTS);
    sts_o.i_ge_n     = i_q >= n_q;
    sts_o.i1_ge_n    = i_plus1 >= {1'b0, n_q};
    sts_o.e_ge_total = e_q >= edge_total_q;
    sts_o.edge_full  = edge_total_q >= ECNT_W'(EDGE_SLOTS);
    sts_o.held_full  = n_q >= LCNT_W'(LOCK_SLOTS);
    sts_o.held_match = held_rdata == lid_q;
    sts_o.edge_match = edge_rdata == pair_q;
    sts_o.peel_done  = k_q == LCNT_W'(LOCK_SLOTS);
  end

  assign total_ext     = {{EU_W{1'b0}}, edge_total_q};
  assign status_o      = status_q;
  assign cycle_found_o = cyc_q;
  assign edges_used_o  = total_ext[EU_W-1:0];

endmodule

// ===== rtl/lodd_ctrl.sv =====
`timescale 1ns / 1ps

module lodd_ctrl import lodd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lodd_sts_t sts_i,
  output lodd_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_A_HRD = 4'd2;
  localparam logic [3:0] S_A_HWT = 4'd3;
  localparam logic [3:0] S_E_RD  = 4'd4;
  localparam logic [3:0] S_E_CMP = 4'd5;
  localparam logic [3:0] S_E_ADD = 4'd6;
  localparam logic [3:0] S_A_PSH = 4'd7;
  localparam logic [3:0] S_R_RD  = 4'd8;
  localparam logic [3:0] S_R_CMP = 4'd9;
  localparam logic [3:0] S_R_SRD = 4'd10;
  localparam logic [3:0] S_R_SWR = 4'd11;
  localparam logic [3:0] S_D_RD  = 4'd12;
  localparam logic [3:0] S_D_ADJ = 4'd13;
  localparam logic [3:0] S_D_PL  = 4'd14;
  localparam logic [3:0] S_RESP  = 4'd15;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_RESP;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.op)
          OP_ACQUIRE: begin
            if (!sts_i.lock_known && sts_i.lock_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.st         = ST_LOCK_FULL;
              state_d          = S_RESP;
            end else begin
              cmd_o.lock_reg = !sts_i.lock_known;
              if (!sts_i.thr_found && sts_i.thr_full) begin
                cmd_o.set_status = 1'b1;
                cmd_o.st         = ST_THREAD_FULL;
                state_d          = S_RESP;
              end else begin
                cmd_o.thr_sel = sts_i.thr_found;
                cmd_o.thr_new = !sts_i.thr_found;
                cmd_o.i_clr   = 1'b1;
                state_d       = S_A_HRD;
              end
            end
          end
          OP_RELEASE: begin
            if (!sts_i.thr_found) begin
              cmd_o.set_status = 1'b1;
              cmd_o.st         = ST_NO_THREAD;
              state_d          = S_RESP;
            end else begin
              cmd_o.thr_sel = 1'b1;
              cmd_o.i_clr   = 1'b1;
              state_d       = S_R_RD;
            end
          end
          OP_DETECT: begin
            cmd_o.adj_clr = 1'b1;
            cmd_o.e_clr   = 1'b1;
            state_d       = S_D_RD;
          end
          default: begin
            cmd_o.clear_tables = 1'b1;
            cmd_o.set_status   = 1'b1;
            cmd_o.st           = ST_OK;
            state_d            = S_RESP;
          end
        endcase
      end
      S_A_HRD: begin
        if (sts_i.i_ge_n) begin
          state_d = S_A_PSH;
        end else begin
          cmd_o.held_rd = 1'b1;
          state_d       = S_A_HWT;
        end
      end
      S_A_HWT: begin
        cmd_o.pair_load = 1'b1;
        cmd_o.e_clr     = 1'b1;
        state_d         = S_E_RD;
      end
      S_E_RD: begin
        if (sts_i.e_ge_total) begin
          state_d = S_E_ADD;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = S_E_CMP;
        end
      end
      S_E_CMP: begin
        if (sts_i.edge_match) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_A_HRD;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = S_E_RD;
        end
      end
      S_E_ADD: begin
        cmd_o.edge_add = !sts_i.edge_full;
        cmd_o.i_inc    = 1'b1;
        state_d        = S_A_HRD;
      end
      S_A_PSH: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.held_full) begin
          cmd_o.st = ST_HELD_FULL;
        end else begin
          cmd_o.held_push = 1'b1;
          cmd_o.st        = ST_OK;
        end
        state_d = S_RESP;
      end
      S_R_RD: begin
        if (sts_i.i_ge_n) begin
          cmd_o.set_status = 1'b1;
          cmd_o.st         = ST_NOT_HELD;
          state_d          = S_RESP;
        end else begin
          cmd_o.held_rd = 1'b1;
          state_d       = S_R_CMP;
        end
      end
      S_R_CMP: begin
        if (sts_i.held_match) begin
          state_d = S_R_SRD;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_R_RD;
        end
      end
      S_R_SRD: begin
        if (sts_i.i1_ge_n) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.st         = ST_OK;
          state_d          = S_RESP;
        end else begin
          cmd_o.held_rd      = 1'b1;
          cmd_o.held_rd_next = 1'b1;
          state_d            = S_R_SWR;
        end
      end
      S_R_SWR: begin
        cmd_o.held_wr_shift = 1'b1;
        cmd_o.i_inc         = 1'b1;
        state_d             = S_R_SRD;
      end
      S_D_RD: begin
        if (sts_i.e_ge_total) begin
          cmd_o.peel_init = 1'b1;
          state_d         = S_D_PL;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = S_D_ADJ;
        end
      end
      S_D_ADJ: begin
        cmd_o.adj_set = 1'b1;
        cmd_o.e_inc   = 1'b1;
        state_d       = S_D_RD;
      end
      S_D_PL: begin
        if (sts_i.peel_done) begin
          cmd_o.set_cycle = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.peel_step = 1'b1;
        end
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lock_order_deadlock_detector.sv =====
`timescale 1ns / 1ps

// Lock-order tracker with deadlock detection.
// The req_i channel carries one transaction per operation: op selects acquire,
// release, detect or clear, and tid and lock_id name the thread and lock.
// The rsp_o channel returns exactly one transaction per request with a status
// code, a cycle flag for detect and the number of stored ordering edges.
// One request is handled at a time: req_i.ready is high only while the block
// is idle, and it stays low until the response has been taken.
// Clear and early failures are answered from the decode state. A release
// searches the thread's held list for the lock, then shifts the later entries
// down over it. An acquire checks every lock that the thread holds against
// the edge table, one entry at a time, and stores each missing ordering edge
// while the edge table has room. A detect builds the adjacency matrix from
// the edge memory, then peels nodes without incoming edges once per cycle.
// Reset empties the lock, thread and edge tables at once; no clearing pass.
// If the receiver stalls, the response holds on rsp_o and no new request is
// accepted until it is taken.
module lock_order_deadlock_detector import lodd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  lodd_in_if.sink  req_i,
  lodd_out_if.source rsp_o
);

  lodd_cmd_t cmd;
  lodd_sts_t sts;

  // The controller sequences each operation; the datapath owns the tables.
  lodd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lodd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (req_i.op),
    .tid_i         (req_i.tid),
    .lock_id_i     (req_i.lock_id),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (rsp_o.status),
    .cycle_found_o (rsp_o.cycle_found),
    .edges_used_o  (rsp_o.edges_used)
  );

  // A response and a new request are never both offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("response pending while a request is accepted");

  // A found cycle is only reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.cycle_found) |-> (rsp_o.status == ST_OK))
    else $error("cycle flag with a failing status");

  // Once a request is taken, no second one is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("back to back request acceptance");

  // The datapath is never told to add an edge past the table end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.edge_add |-> !sts.edge_full)
    else $error("edge written into a full table");

endmodule
